// File: rtl/gdre_pkg.sv
// ----------------------------------------------------------------------------
// gdre_pkg
// shared types and constants of the greedy-dual replacement engine
// ----------------------------------------------------------------------------
package gdre_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 3;
  localparam int KLEN_W   = 10;
  localparam int VLEN_W   = 24;
  localparam int BYTES_W  = 40;
  localparam int PRIO_W   = 32;
  localparam int ORDER_W  = 32;

  localparam logic [BYTES_W-1:0] BYTES_MAX      = {BYTES_W{1'b1}};
  localparam logic [BYTES_W-1:0] ENTRY_OVERHEAD = 40'd24;
  localparam logic [BYTES_W-1:0] CAPACITY_RESET = 40'd1073741824;
  localparam logic [PRIO_W-1:0]  PRIO_MAX       = {PRIO_W{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_EXISTS    = 3'd0,
    ACT_LOOKUP    = 3'd1,
    ACT_UPDATE    = 3'd2,
    ACT_ADMIT     = 3'd3,
    ACT_PEEK      = 3'd4,
    ACT_EVICT_KEY = 3'd5,
    ACT_EVICT_MIN = 3'd6,
    ACT_NONE      = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MISS      = 3'd0,
    ST_DONE      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_OVER_CAP  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_READ,
    S_WAIT,
    S_EXEC,
    S_OUT
  } state_t;

endpackage

// File: rtl/gdre_ram.sv
// ----------------------------------------------------------------------------
// gdre_ram
// generic single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module gdre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/greedy_dual_replacement_engine.sv
// ----------------------------------------------------------------------------
// greedy_dual_replacement_engine
// greedy-dual cache replacement table kept in on-chip ram
// ----------------------------------------------------------------------------
// One item at a time. Each action scans all ENTRIES slots through the entry
// ram, one slot per cycle, tracking key match, lowest free slot and victim,
// then rereads the chosen slot and, for lookup, update and admit, writes it
// back. Valid bits live in flip-flops cleared by reset, so no clearing pass.
module greedy_dual_replacement_engine
  import gdre_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int KEY_BITS    = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [39:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0], key[66:3], key_bytes[76:67], value_bytes[100:77],
  // value_handle[132:101], zero fill
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], key_out[66:3], key_bytes_out[76:67], value_bytes_out[100:77],
  // value_handle_out[132:101], used_bytes[172:133], zero fill
  output logic [175:0] m_tdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int EW = KEY_BITS + KLEN_W + VLEN_W + HANDLE_BITS + PRIO_W + ORDER_W;

  state_t state, state_next;

  logic [BYTES_W-1:0]     capacity;
  logic [ENTRIES-1:0]     valid;
  logic [PRIO_W-1:0]      level;
  logic [BYTES_W-1:0]     used;
  logic [ORDER_W-1:0]     counter;

  action_t                act;
  logic [KEY_BITS-1:0]    in_key;
  logic [KLEN_W-1:0]      in_klen;
  logic [VLEN_W-1:0]      in_vlen;
  logic [HANDLE_BITS-1:0] in_handle;

  logic [IW-1:0]          addr, scan_idx, rd_idx, rd_idx_d;
  logic                   scan_live;
  logic                   hit, free_found, vic_found;
  logic [IW-1:0]          hit_idx, free_idx, vic_idx;
  logic [PRIO_W-1:0]      vic_prio;
  logic [ORDER_W-1:0]     vic_age;

  logic                   we;
  logic [EW-1:0]          wdata, rdata;

  logic [KEY_BITS-1:0]    r_key;
  logic [KLEN_W-1:0]      r_klen;
  logic [VLEN_W-1:0]      r_vlen;
  logic [HANDLE_BITS-1:0] r_handle;
  logic [PRIO_W-1:0]      r_prio;
  logic [ORDER_W-1:0]     r_order;
  logic [ORDER_W-1:0]     age;

  logic [2:0]             o_status;
  logic [63:0]            o_key;
  logic [KLEN_W-1:0]      o_klen;
  logic [VLEN_W-1:0]      o_vlen;
  logic [31:0]            o_handle;

  status_t                status_next;
  logic [63:0]            key_next;
  logic [KLEN_W-1:0]      klen_next;
  logic [VLEN_W-1:0]      vlen_next;
  logic [31:0]            handle_next;
  logic                   report_entry, report_input;

  assign {r_key, r_klen, r_vlen, r_handle, r_prio, r_order} = rdata;
  assign age       = counter - r_order;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {3'd0, used, o_handle, o_vlen, o_klen, o_key, o_status};

  gdre_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_SCAN;
      S_SCAN: if (scan_idx == IW'(ENTRIES - 1)) state_next = S_LAST;
      S_LAST: state_next = S_READ;
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // slot choice once the scan is over
  always_comb begin
    rd_idx = hit_idx;
    if (act == ACT_PEEK || act == ACT_EVICT_MIN) begin
      rd_idx = vic_idx;
    end else if (act == ACT_ADMIT) begin
      rd_idx = free_idx;
    end
    addr = (state == S_SCAN) ? scan_idx : rd_idx;
  end

  logic [PRIO_W-1:0]  newprio;
  logic [BYTES_W:0]   sum_up;
  logic [BYTES_W-1:0] up_sat, charge, upd_bytes, obj, admit_bytes;
  assign newprio = (level == PRIO_MAX) ? PRIO_MAX : level + 1'b1;
  assign obj     = BYTES_W'(in_klen) + BYTES_W'(in_vlen);
  assign charge  = BYTES_W'({r_klen, 1'b0}) + BYTES_W'(r_vlen) + ENTRY_OVERHEAD;
  assign sum_up  = {1'b0, used} + (BYTES_W+1)'(in_vlen);
  assign up_sat  = sum_up[BYTES_W] ? BYTES_MAX : sum_up[BYTES_W-1:0];
  assign upd_bytes = (up_sat > BYTES_W'(r_vlen)) ? up_sat - BYTES_W'(r_vlen) : '0;
  logic [BYTES_W:0] adm_sum;
  assign adm_sum = {1'b0, used} + {1'b0, BYTES_W'({in_klen, 1'b0}) + BYTES_W'(in_vlen)
                   + ENTRY_OVERHEAD};
  assign admit_bytes = adm_sum[BYTES_W] ? BYTES_MAX : adm_sum[BYTES_W-1:0];

  always_comb begin
    we    = 1'b0;
    wdata = {r_key, r_klen, r_vlen, r_handle, newprio, counter};
    if (state == S_EXEC) begin
      unique case (act)
        ACT_LOOKUP: we = hit;
        ACT_UPDATE: begin
          we    = hit;
          wdata = {r_key, r_klen, in_vlen, in_handle, newprio, counter};
        end
        ACT_ADMIT: begin
          we    = !hit && (obj < capacity) && ({1'b0, used} + {1'b0, obj}
                  <= {1'b0, capacity}) && free_found;
          wdata = {in_key, in_klen, in_vlen, in_handle, newprio, counter};
        end
        default: we = 1'b0;
      endcase
    end
  end

  // result fields, zero unless an entry or the admitted input is reported
  always_comb begin
    status_next  = ST_MISS;
    report_entry = 1'b0;
    report_input = 1'b0;
    unique case (act)
      ACT_EXISTS, ACT_LOOKUP, ACT_EVICT_KEY: if (hit) begin
        status_next  = ST_DONE;
        report_entry = 1'b1;
      end
      ACT_PEEK, ACT_EVICT_MIN: if (vic_found) begin
        status_next  = ST_DONE;
        report_entry = 1'b1;
      end
      ACT_UPDATE: if (hit) begin
        status_next  = (upd_bytes > capacity) ? ST_OVER_CAP : ST_DONE;
        report_entry = 1'b1;
      end
      ACT_ADMIT: begin
        priority if (hit) status_next = ST_MISS;
        else if (obj >= capacity) status_next = ST_TOO_LARGE;
        else if ({1'b0, used} + {1'b0, obj} > {1'b0, capacity}) status_next = ST_FULL;
        else if (!free_found) status_next = ST_NO_SLOT;
        else begin
          status_next  = ST_DONE;
          report_input = 1'b1;
        end
      end
      default: status_next = ST_MISS;
    endcase
    key_next    = '0;
    klen_next   = '0;
    vlen_next   = '0;
    handle_next = '0;
    if (report_entry) begin
      key_next    = 64'(r_key);
      klen_next   = r_klen;
      vlen_next   = (act == ACT_UPDATE) ? in_vlen : r_vlen;
      handle_next = (act == ACT_UPDATE) ? 32'(in_handle) : 32'(r_handle);
    end else if (report_input) begin
      key_next    = 64'(in_key);
      klen_next   = in_klen;
      vlen_next   = in_vlen;
      handle_next = 32'(in_handle);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAPACITY_RESET;
      valid    <= '0;
      level    <= '0;
      used     <= '0;
      counter  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) capacity <= cfg_data;
      if (state == S_EXEC) begin
        unique case (act)
          ACT_LOOKUP: if (hit) counter <= counter + 1'b1;
          ACT_UPDATE: if (hit) begin
            counter <= counter + 1'b1;
            used    <= upd_bytes;
          end
          ACT_ADMIT: if (we) begin
            counter         <= counter + 1'b1;
            used            <= admit_bytes;
            valid[free_idx] <= 1'b1;
          end
          ACT_EVICT_KEY: if (hit) begin
            valid[hit_idx] <= 1'b0;
            used <= (used > charge) ? used - charge : '0;
          end
          ACT_EVICT_MIN: if (vic_found) begin
            valid[vic_idx] <= 1'b0;
            level <= r_prio;
            used  <= (used > charge) ? used - charge : '0;
          end
          default: ;
        endcase
      end
    end
  end

  // scan and result datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      act        <= action_t'(s_tdata[2:0]);
      in_key     <= s_tdata[3 +: KEY_BITS];
      in_klen    <= s_tdata[76:67];
      in_vlen    <= s_tdata[100:77];
      in_handle  <= HANDLE_BITS'(s_tdata[132:101]);
      scan_idx   <= '0;
      scan_live  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
      hit_idx    <= '0;
      free_idx   <= '0;
      vic_idx    <= '0;
    end
    if (state == S_SCAN) begin
      scan_idx  <= scan_idx + 1'b1;
      scan_live <= 1'b1;
      rd_idx_d  <= scan_idx;
      if (!valid[scan_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
    end
    if ((state == S_SCAN || state == S_LAST) && scan_live && valid[rd_idx_d]) begin
      if (!hit && r_key == in_key) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx_d;
      end
      if (!vic_found || r_prio < vic_prio || (r_prio == vic_prio && age > vic_age)) begin
        vic_found <= 1'b1;
        vic_idx   <= rd_idx_d;
        vic_prio  <= r_prio;
        vic_age   <= age;
      end
    end
    if (state == S_EXEC) begin
      o_status <= status_next;
      o_key    <= key_next;
      o_klen   <= klen_next;
      o_vlen   <= vlen_next;
      o_handle <= handle_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while result pending");
  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_EXEC) else $error("ram write outside execute");
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> m_tvalid) else $error("result not presented");

endmodule
